// ----- rtl/core/ftvp_pkg.sv -----
// Shared types and constants of the framed tag/value parser.
package ftvp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FIRST  = 4'd0,
    CFG_START_SECOND = 4'd1,
    CFG_END_FIRST    = 4'd2,
    CFG_END_SECOND   = 4'd3
  } ftvp_cfg_idx_e;

  // Parse phases, one-hot.
  typedef enum logic [8:0] {
    PH_START0 = 9'b0_0000_0001,
    PH_START1 = 9'b0_0000_0010,
    PH_TAG    = 9'b0_0000_0100,
    PH_DATA0  = 9'b0_0000_1000,
    PH_DATA1  = 9'b0_0001_0000,
    PH_DATA2  = 9'b0_0010_0000,
    PH_DATA3  = 9'b0_0100_0000,
    PH_END0   = 9'b0_1000_0000,
    PH_END1   = 9'b1_0000_0000
  } ftvp_phase_e;

  // The four marker bytes as seen by the parser.
  typedef struct packed {
    logic [ByteW-1:0] start_first;
    logic [ByteW-1:0] start_second;
    logic [ByteW-1:0] end_first;
    logic [ByteW-1:0] end_second;
  } ftvp_markers_t;

  // A completed frame leaving the parser.
  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  tag;
    logic [ValueW-1:0] value;
  } ftvp_result_t;

endpackage

// ----- rtl/core/ftvp_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded frames.
interface ftvp_byte_if
  import ftvp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ftvp_frame_if
  import ftvp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  frame_tag;
  logic [ValueW-1:0] frame_value;

  modport source (output valid, output frame_tag, output frame_value, input ready);
  modport sink (input valid, input frame_tag, input frame_value, output ready);
endinterface

// ----- rtl/core/ftvp_cfg_regs.sv -----
// Marker byte configuration registers.
module ftvp_cfg_regs
  import ftvp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output ftvp_markers_t       markers_o
);

  ftvp_markers_t markers_q, markers_d;

  // Decode the write; an index beyond the list is ignored.
  always_comb begin
    markers_d = markers_q;
    if (cfg_we_i) begin
      case (ftvp_cfg_idx_e'(cfg_idx_i))
        CFG_START_FIRST:  markers_d.start_first  = cfg_data_i[ByteW-1:0];
        CFG_START_SECOND: markers_d.start_second = cfg_data_i[ByteW-1:0];
        CFG_END_FIRST:    markers_d.end_first    = cfg_data_i[ByteW-1:0];
        CFG_END_SECOND:   markers_d.end_second   = cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q <= '0;
    end else begin
      markers_q <= markers_d;
    end
  end

  assign markers_o = markers_q;

endmodule

// ----- rtl/core/ftvp_parser.sv -----
// Frame phase machine with the held tag and value.
module ftvp_parser
  import ftvp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  ftvp_markers_t    markers_i,
  output ftvp_result_t     result_o
);

  ftvp_phase_e       phase_q, phase_d;
  logic [ByteW-1:0]  tag_q, tag_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              hit;

  // Next phase and payload capture for the byte presented this cycle.
  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    value_d = value_q;
    hit     = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_START0: phase_d = (byte_i == markers_i.start_first) ? PH_START1 : PH_START0;
        PH_START1: phase_d = (byte_i == markers_i.start_second) ? PH_TAG : PH_START0;
        PH_TAG: begin
          tag_d   = byte_i;
          value_d = '0;
          phase_d = PH_DATA0;
        end
        PH_DATA0: begin
          value_d = {byte_i, 24'd0};
          phase_d = PH_DATA1;
        end
        PH_DATA1: begin
          value_d = {value_q[31:24], byte_i, value_q[15:0]};
          phase_d = PH_DATA2;
        end
        PH_DATA2: begin
          value_d = {value_q[31:16], byte_i, value_q[7:0]};
          phase_d = PH_DATA3;
        end
        PH_DATA3: begin
          value_d = {value_q[31:8], byte_i};
          phase_d = PH_END0;
        end
        PH_END0: phase_d = (byte_i == markers_i.end_first) ? PH_END1 : PH_START0;
        PH_END1: begin
          hit     = (byte_i == markers_i.end_second);
          phase_d = PH_START0;
        end
        default: phase_d = PH_START0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START0;
      tag_q   <= '0;
      value_q <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      value_q <= value_d;
    end
  end

  // A frame is complete when the second end marker matches.
  assign result_o.valid = hit;
  assign result_o.tag   = tag_q;
  assign result_o.value = value_q;

endmodule

// ----- rtl/core/framed_tag_value_parser.sv -----
// Top level of the framed tag/value parser.
//
// Received bytes arrive one per beat on the rx channel; a decoded frame
// (tag byte and 32-bit value, first data byte in the top bits) leaves as one
// beat on the frame channel. A frame is two start markers, the tag, four
// value bytes and two end markers; the marker bytes are set through the
// write port (index 0..3), and the user is to set them only while the block
// is idle; the block itself does not enforce this. Each byte is first taken
// into an input register, then run through the phase machine into the output
// register, which takes a frame beat as its last end marker byte passes
// the phase machine. One byte is accepted every cycle while no frame beat
// is stalled. When the receiver stalls, the waiting frame beat holds in the
// output register, and one more byte is taken into the input register only
// if it is empty; then rx ready is low until the frame beat is taken.
// Reset empties both registers, clears the markers to zero and puts the
// parser back to hunting for the first start marker.
module framed_tag_value_parser
  import ftvp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ftvp_byte_if.sink           rx,
  ftvp_frame_if.source        frame,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ftvp_markers_t     markers;
  ftvp_result_t      result;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q;
  logic [ByteW-1:0]  out_tag_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_free;
  logic              step;

  ftvp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .markers_o  (markers)
  );

  // Handshake between the two registers.
  assign out_free = !out_valid_q || frame.ready;
  assign step     = in_valid_q && out_free;
  assign rx.ready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx.ready) begin
      in_valid_q <= rx.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.ready && rx.valid) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  ftvp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .markers_i (markers),
    .result_o  (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && result.valid) begin
      out_tag_q   <= result.tag;
      out_value_q <= result.value;
    end
  end

  assign frame.valid       = out_valid_q;
  assign frame.frame_tag   = out_tag_q;
  assign frame.frame_value = out_value_q;

endmodule

// ----- rtl/core/ftvp_checker.sv -----
// Port-level checks of the framed tag/value parser and their bind.
module ftvp_checker
  import ftvp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rx_valid_i,
  input logic              rx_ready_i,
  input logic              fr_valid_i,
  input logic              fr_ready_i,
  input logic [ByteW-1:0]  fr_tag_i,
  input logic [ValueW-1:0] fr_value_i
);

  // A stalled frame beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid_i && !fr_ready_i |=> fr_valid_i)
    else $error("frame beat withdrawn while stalled");

  // A stalled frame beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid_i && !fr_ready_i |=> $stable(fr_tag_i) && $stable(fr_value_i))
    else $error("frame payload changed while stalled");

  // The byte side only backs up behind a stalled frame beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> fr_valid_i && !fr_ready_i)
    else $error("rx ready low without a stalled frame beat");

  // A fresh frame beat follows an accepted byte, through the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fr_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2))
    else $error("frame beat without a byte accepted two cycles before");

endmodule

bind framed_tag_value_parser ftvp_checker u_ftvp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid_i (rx.valid),
  .rx_ready_i (rx.ready),
  .fr_valid_i (frame.valid),
  .fr_ready_i (frame.ready),
  .fr_tag_i   (frame.frame_tag),
  .fr_value_i (frame.frame_value)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the framed tag/value parser.
module tb_top;
  import ftvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes  = 1500;
  localparam int unsigned RandomRounds = 6;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned LongHold     = 40;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned CfgIdxSpareLo = 4;
  localparam int unsigned CfgIdxMax     = (1 << CfgIdxW) - 1;

  // Where a sent frame is deliberately spoilt.
  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_START_FIRST,
    FAULT_START_SECOND,
    FAULT_END_FIRST,
    FAULT_END_SECOND
  } frame_fault_e;

  // Kinds of marker sets used across the random rounds.
  typedef enum int unsigned {
    MK_RANDOM,
    MK_EQUAL,
    MK_ZERO,
    MK_ONES
  } marker_set_e;

  typedef struct packed {
    logic [ByteW-1:0]  tag;
    logic [ValueW-1:0] value;
  } frame_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ftvp_byte_if  rx_ch ();
  ftvp_frame_if frame_ch ();

  framed_tag_value_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx_ch),
    .frame      (frame_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Parser state as predicted by the testbench.
  ftvp_markers_t     marker_regs;
  ftvp_phase_e       hunt_phase;
  logic [ByteW-1:0]  held_tag;
  logic [ValueW-1:0] held_value;
  frame_t            pending_frames[$];
  frame_t            oldest_frame;

  int unsigned failures;
  int unsigned bytes_accepted;
  int unsigned cycle_count;
  int unsigned idle_odds;
  bit          quiet_tail;
  bit          long_hold_req;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Abandon the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Advance the predicted phase machine by one received byte.
  task automatic track_rx_byte(input logic [ByteW-1:0] b);
    case (hunt_phase)
      PH_START0: hunt_phase = (b == marker_regs.start_first) ? PH_START1 : PH_START0;
      PH_START1: hunt_phase = (b == marker_regs.start_second) ? PH_TAG : PH_START0;
      PH_TAG: begin
        held_tag   = b;
        held_value = '0;
        hunt_phase = PH_DATA0;
      end
      PH_DATA0: begin
        held_value[31:24] = b;
        hunt_phase        = PH_DATA1;
      end
      PH_DATA1: begin
        held_value[23:16] = b;
        hunt_phase        = PH_DATA2;
      end
      PH_DATA2: begin
        held_value[15:8] = b;
        hunt_phase       = PH_DATA3;
      end
      PH_DATA3: begin
        held_value[7:0] = b;
        hunt_phase      = PH_END0;
      end
      PH_END0: hunt_phase = (b == marker_regs.end_first) ? PH_END1 : PH_START0;
      PH_END1: begin
        if (b == marker_regs.end_second) begin
          pending_frames.push_back('{tag: held_tag, value: held_value});
        end
        hunt_phase = PH_START0;
      end
      default: hunt_phase = PH_START0;
    endcase
  endtask

  // Check frame beats against the oldest prediction, then track accepted bytes.
  always @(posedge clk_i) begin
    if (rst_ni && frame_ch.valid && frame_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: tag %0h value %0h", frame_ch.frame_tag,
               frame_ch.frame_value);
        failures++;
      end else begin
        oldest_frame = pending_frames.pop_front();
        if (frame_ch.frame_tag !== oldest_frame.tag) begin
          $error("frame_tag: expected %0h, got %0h", oldest_frame.tag, frame_ch.frame_tag);
          failures++;
        end
        if (frame_ch.frame_value !== oldest_frame.value) begin
          $error("frame_value: expected %0h, got %0h", oldest_frame.value,
                 frame_ch.frame_value);
          failures++;
        end
      end
    end
    if (rst_ni && rx_ch.valid && rx_ch.ready) begin
      track_rx_byte(rx_ch.rx_byte);
      bytes_accepted++;
    end
  end

  // Frame receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    frame_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        frame_ch.ready = 1'b0;
        for (int i = 1; i < LongHold; i++) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (!quiet_tail && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        frame_ch.ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        frame_ch.ready = 1'b1;
      end
    end
  end

  // Offer one byte and hold it until it is taken. Called at a falling edge.
  task automatic send_rx_byte(input logic [ByteW-1:0] b);
    if (!quiet_tail && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      rx_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk_i); while (!rx_ch.ready);
    @(negedge clk_i);
  endtask

  // Send a nine-byte frame, optionally with one marker byte spoilt.
  task automatic send_frame(input logic [ByteW-1:0] tag, input logic [ValueW-1:0] value,
                            input frame_fault_e fault);
    logic [ByteW-1:0] seq[9];
    seq = '{marker_regs.start_first, marker_regs.start_second, tag,
            value[31:24], value[23:16], value[15:8], value[7:0],
            marker_regs.end_first, marker_regs.end_second};
    case (fault)
      FAULT_START_FIRST:  seq[0] ^= ByteW'($urandom_range(1, 255));
      FAULT_START_SECOND: seq[1] ^= ByteW'($urandom_range(1, 255));
      FAULT_END_FIRST:    seq[7] ^= ByteW'($urandom_range(1, 255));
      FAULT_END_SECOND:   seq[8] ^= ByteW'($urandom_range(1, 255));
      default: ;
    endcase
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  // Drop valid and wait until every predicted frame has come out.
  task automatic wait_idle();
    rx_ch.valid = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one configuration register. Called at a falling edge.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      CFG_START_FIRST:  marker_regs.start_first  = data;
      CFG_START_SECOND: marker_regs.start_second = data;
      CFG_END_FIRST:    marker_regs.end_first    = data;
      CFG_END_SECOND:   marker_regs.end_second   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_markers(input logic [ByteW-1:0] sf, input logic [ByteW-1:0] ss,
                             input logic [ByteW-1:0] ef, input logic [ByteW-1:0] es);
    write_cfg(CFG_START_FIRST, sf);
    write_cfg(CFG_START_SECOND, ss);
    write_cfg(CFG_END_FIRST, ef);
    write_cfg(CFG_END_SECOND, es);
  endtask

  // Markers still at their reset value of zero, with extreme tags and values.
  task automatic test_reset_markers();
    send_frame('0, '0, FAULT_NONE);
    send_frame('1, '1, FAULT_NONE);
  endtask

  // Each marker spoilt in turn; a repeated first start byte is not looked at again.
  task automatic test_marker_faults();
    wait_idle();
    set_markers(8'hA5, 8'h5A, 8'hC3, 8'h3C);
    send_frame(8'h12, 32'h8000_0001, FAULT_START_FIRST);
    send_frame(8'h34, 32'h0123_4567, FAULT_START_SECOND);
    send_frame(8'h56, 32'h89AB_CDEF, FAULT_END_FIRST);
    send_frame(8'h78, 32'hFEDC_BA98, FAULT_END_SECOND);
    send_rx_byte(marker_regs.start_first);
    send_frame(8'h9A, 32'h7FFF_FFFE, FAULT_NONE);
    send_frame(8'hBC, 32'h5555_AAAA, FAULT_NONE);
  endtask

  // All four markers equal and at the top of the byte range.
  task automatic test_equal_markers();
    wait_idle();
    set_markers('1, '1, '1, '1);
    send_frame('1, '1, FAULT_NONE);
    send_frame('0, '0, FAULT_NONE);
  endtask

  // A write to an index past the last register must leave the markers alone.
  task automatic test_spare_index();
    wait_idle();
    write_cfg(CfgIdxW'($urandom_range(CfgIdxMax, CfgIdxSpareLo)),
              CfgDataW'($urandom));
    send_frame(8'h5A, 32'hA5A5_5A5A, FAULT_NONE);
  endtask

  // Hold the receiver off for a long stretch while frames keep coming.
  task automatic test_back_pressure();
    wait_idle();
    idle_odds     = 0;
    long_hold_req = 1'b1;
    repeat (5) send_frame(ByteW'($urandom), ValueW'($urandom), FAULT_NONE);
  endtask

  // Rounds of mostly good frames with random content, some broken frames and noise.
  task automatic test_random_traffic();
    int unsigned   first_byte;
    int unsigned   pick;
    marker_set_e   kind;
    logic [ByteW-1:0] same;
    first_byte = bytes_accepted;
    for (int unsigned r = 0; r < RandomRounds; r++) begin
      wait_idle();
      kind = (r < 4) ? marker_set_e'(r) : MK_RANDOM;
      same = ByteW'($urandom);
      case (kind)
        MK_EQUAL: set_markers(same, same, same, same);
        MK_ZERO:  set_markers('0, '0, '0, '0);
        MK_ONES:  set_markers('1, '1, '1, '1);
        default:  set_markers(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                              ByteW'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       idle_odds = 0;
        1:       idle_odds = 2;
        2:       idle_odds = 4;
        default: idle_odds = 8;
      endcase
      quiet_tail = (r == RandomRounds - 1);
      while (bytes_accepted - first_byte < (r + 1) * RandomBytes / RandomRounds) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame(ByteW'($urandom), ValueW'($urandom), FAULT_NONE);
        end else if (pick < 85) begin
          send_frame(ByteW'($urandom), ValueW'($urandom),
                     frame_fault_e'($urandom_range(FAULT_START_FIRST, FAULT_END_SECOND)));
        end else begin
          repeat ($urandom_range(1, 6)) send_rx_byte(ByteW'($urandom));
        end
      end
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    marker_regs   = '0;
    hunt_phase    = PH_START0;
    held_tag      = '0;
    held_value    = '0;
    failures      = 0;
    idle_odds     = 4;
    quiet_tail    = 1'b0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_markers();
    test_marker_faults();
    test_equal_markers();
    test_spare_index();
    test_back_pressure();
    test_random_traffic();
    wait_idle();

    if (failures == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
